// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, ignoring cycles in reset.
`define IIAR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define IIAR_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: rtl/iiar_pkg.sv
package iiar_pkg;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_READ   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  localparam int unsigned PosW  = 9;
  localparam int unsigned CntW  = 9;

  typedef struct packed {
    req_type_e          req_type;
    logic [PosW-1:0]    position;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] read_value;
    logic [CntW-1:0]    entry_count;
  } rsp_t;

  // Per-cell command for one transfer.
  typedef struct packed {
    logic load;        // take the new value
    logic shift_up;    // take the lower neighbor's entry
    logic shift_down;  // take the upper neighbor's entry
    logic rd_sel;      // drive own entry onto the read reduction
  } cell_ctl_t;

endpackage

// File: rtl/iiar_cell.sv
module iiar_cell (
  input  logic               clk_i,
  input  iiar_pkg::cell_ctl_t ctl_i,
  input  logic signed [31:0] item_i,
  input  logic signed [31:0] lower_i,
  input  logic signed [31:0] upper_i,
  output logic signed [31:0] data_o,
  output logic signed [31:0] rd_o
);
  import iiar_pkg::*;

  logic signed [31:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.load) begin
      data_d = item_i;
    end else if (ctl_i.shift_up) begin
      data_d = lower_i;
    end else if (ctl_i.shift_down) begin
      data_d = upper_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = ctl_i.rd_sel ? data_q : '0;

endmodule

// File: rtl/indexed_insert_remove_array_core.sv
// Channel | Direction | Handshake                 | Payload
// --------+-----------+---------------------------+-----------------------------------
// in      | input     | in_valid_i / in_ready_o   | in_req_i  (req_type, position, item_value)
// out     | output    | out_valid_o / out_ready_i | out_rsp_o (status, read_value, entry_count)
//
// Sustained rate is one transfer per cycle while out is not stalled; each result is
// held in the read stage between the two reduction levels, then in the result register.
// Append, insert and remove update the whole cell row in the accepting cycle: every
// cell above the index (from it up on remove) takes its neighbor's entry at the same edge.
// Reset clears the entry count and the valid flags only; entries need no clearing.
// A stall on out holds the result register; in stays open while the read stage is
// empty or can drain into it, so one request may sit behind a waiting result.
module indexed_insert_remove_array_core #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  iiar_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output iiar_pkg::rsp_t out_rsp_o
);
  import iiar_pkg::*;

  localparam int unsigned CW     = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW   = (CW > PosW) ? CW : PosW;
  localparam int unsigned EXTW   = CW + CntW;
  localparam int unsigned GrpSz  = 16;
  localparam int unsigned NumGrp = (CAPACITY + GrpSz - 1) / GrpSz;

  // Entry count
  logic [CW-1:0] count_q, count_d;

  // Read stage: one request between transfer and the result register
  logic                    s1_valid_q;
  status_e                 s1_status_q, s1_status_d;
  logic [CntW-1:0]         s1_count_q;
  logic signed [31:0]      grp_q [NumGrp];
  logic signed [31:0]      grp_d [NumGrp];

  // Result register
  logic out_valid_q;
  rsp_t rsp_q;

  logic in_fire, out_free, s1_adv;

  // Request decode
  logic [CMPW-1:0] pos_c, cnt_c, target_c;
  logic            do_ins, do_rem, do_rd, full;
  logic [EXTW-1:0] cnt_ext;

  // Cell row
  cell_ctl_t          ctl   [CAPACITY];
  logic signed [31:0] cell_data [CAPACITY];
  logic signed [31:0] cell_rd   [NumGrp*GrpSz];
  logic signed [31:0] rd_final;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign pos_c = CMPW'(in_req_i.position);
  assign cnt_c = CMPW'(count_q);
  assign full  = (cnt_c >= CMPW'(CAPACITY));

  // Decide status and which row operation to run
  always_comb begin
    s1_status_d = ST_OK;
    do_ins      = 1'b0;
    do_rem      = 1'b0;
    do_rd       = 1'b0;
    target_c    = pos_c;
    case (in_req_i.req_type)
      REQ_APPEND: begin
        target_c = cnt_c;
        if (full) begin
          s1_status_d = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      REQ_INSERT: begin
        if (pos_c > cnt_c) begin
          s1_status_d = ST_RANGE;
        end else if (full) begin
          s1_status_d = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (pos_c >= cnt_c) begin
          s1_status_d = ST_RANGE;
        end else begin
          do_rem = 1'b1;
        end
      end
      REQ_READ: begin
        if (pos_c >= cnt_c) begin
          s1_status_d = ST_RANGE;
        end else begin
          do_rd = 1'b1;
        end
      end
      default: begin
        s1_status_d = ST_RANGE;
      end
    endcase
  end

  // Advance the count only on a transfer that changes the list
  always_comb begin
    count_d = count_q;
    if (in_fire && do_ins) begin
      count_d = count_q + 1'b1;
    end else if (in_fire && do_rem) begin
      count_d = count_q - 1'b1;
    end
  end

  assign cnt_ext = {{CntW{1'b0}}, count_d};

  // Cell row: each cell compares its own index against the target
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] lower, upper;

    always_comb begin
      ctl[i].load       = in_fire && do_ins && (CMPW'(i) == target_c);
      ctl[i].shift_up   = in_fire && do_ins && (CMPW'(i) >  target_c);
      ctl[i].shift_down = in_fire && do_rem && (CMPW'(i) >= target_c);
      ctl[i].rd_sel     = do_rd && (CMPW'(i) == target_c);
    end

    if (i == 0) begin : g_bot
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_data[i+1];
    end

    iiar_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl[i]),
      .item_i (in_req_i.item_value),
      .lower_i(lower),
      .upper_i(upper),
      .data_o (cell_data[i]),
      .rd_o   (cell_rd[i])
    );
  end

  // Pad the read lines to whole groups
  for (genvar i = CAPACITY; i < NumGrp * GrpSz; i++) begin : g_pad
    assign cell_rd[i] = '0;
  end

  // First reduction level: OR within each group of cells
  always_comb begin
    for (int g = 0; g < NumGrp; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GrpSz; k++) begin
        grp_d[g] = grp_d[g] | cell_rd[g*GrpSz + k];
      end
    end
  end

  // Second reduction level: OR across groups
  always_comb begin
    rd_final = '0;
    for (int g = 0; g < NumGrp; g++) begin
      rd_final = rd_final | grp_q[g];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: capture on transfer, hold on stall
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_status_q <= s1_status_d;
      s1_count_q  <= cnt_ext[CntW-1:0];
      grp_q       <= grp_d;
    end
    if (s1_adv) begin
      rsp_q.status      <= s1_status_q;
      rsp_q.read_value  <= rd_final;
      rsp_q.entry_count <= s1_count_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  `include "assert_macros.svh"

  `IIAR_NEVER(a_count_in_range, count_q > CW'(CAPACITY))
  `IIAR_ASSERT(a_count_only_on_transfer, !in_fire |=> $stable(count_q))
  `IIAR_ASSERT(a_stage_holds_on_stall, (s1_valid_q && !out_free) |=> s1_valid_q)

endmodule

// File: tb/sv/indexed_insert_remove_array_core_tb.sv
`timescale 1ns / 1ps

module indexed_insert_remove_array_core_tb;
  import iiar_pkg::*;

  localparam int CAPACITY     = 256;
  localparam int RANDOM_ITEMS = 750;
  // Cycles watched for stray results once every expected result has arrived.
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  // Steering of the random part: fill the list, hammer it while full,
  // drain it, then mix for a while before filling again.
  typedef enum {MODE_GROW, MODE_FULL, MODE_SHRINK, MODE_MIXED} list_mode_e;

  typedef struct {
    req_t req;
    bit   typed;  // rsp below was written by hand
    rsp_t rsp;
  } stim_row_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  req_t in_req_i    = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_rsp_o;

  // Shadow copy of the list, advanced on every accepted request.
  logic signed [31:0] shadow_list [CAPACITY];
  int                 shadow_count = 0;
  rsp_t               pending_rsps [$];

  int fail_count  = 0;
  int cycle_count = 0;
  int burst_left  = 0;

  indexed_insert_remove_array_core #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Apply one request to the shadow list and return the response it earns.
  function automatic rsp_t shadow_apply(req_t r);
    rsp_t o;
    int   p;
    o.status     = ST_OK;
    o.read_value = '0;
    p = int'(r.position);
    case (r.req_type)
      REQ_APPEND: begin
        if (shadow_count >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          shadow_list[shadow_count] = r.item_value;
          shadow_count++;
        end
      end
      REQ_INSERT: begin
        // Range check wins over the full check.
        if (p > shadow_count) begin
          o.status = ST_RANGE;
        end else if (shadow_count >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          for (int i = shadow_count; i > p; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p] = r.item_value;
          shadow_count++;
        end
      end
      REQ_REMOVE: begin
        if (p >= shadow_count) begin
          o.status = ST_RANGE;
        end else begin
          for (int i = p; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end
      end
      default: begin
        if (p >= shadow_count || p >= CAPACITY) o.status = ST_RANGE;
        else o.read_value = shadow_list[p];
      end
    endcase
    o.entry_count = CntW'(shadow_count);
    return o;
  endfunction

  function automatic stim_row_t row(req_type_e t, int pos, logic [31:0] v, bit typed,
                                    status_e st, logic [31:0] rd, int cnt);
    stim_row_t s;
    s.req.req_type    = t;
    s.req.position    = PosW'(pos);
    s.req.item_value  = v;
    s.typed           = typed;
    s.rsp.status      = st;
    s.rsp.read_value  = rd;
    s.rsp.entry_count = CntW'(cnt);
    return s;
  endfunction

  // Present one request, hold it until the transfer, then record its response.
  // Called at a rising edge; returns at the edge where the transfer happened.
  task automatic send_request(input req_t r, input bit typed, input rsp_t typed_rsp);
    rsp_t predicted;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
      // Now and then a long burst so the block also runs with no idle input.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 200)
                                               : $urandom_range(1, 30);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    predicted = shadow_apply(r);
    if (typed) predicted = typed_rsp;
    pending_rsps = {pending_rsps, predicted};
    burst_left--;
  endtask

  // Receiver: switch between always ready, scattered stalls and long stalls.
  int rx_mode     = 0;
  int rx_window   = 0;
  int rx_stall    = 0;
  always @(posedge clk_i) begin
    if (rx_window == 0) begin
      rx_mode   <= $urandom_range(0, 2);
      rx_window <= $urandom_range(20, 120);
    end else begin
      rx_window <= rx_window - 1;
    end
    if (rx_stall > 0) begin
      rx_stall    <= rx_stall - 1;
      out_ready_i <= 1'b0;
    end else if (rx_mode == 1) begin
      out_ready_i <= ($urandom_range(0, 3) != 0);
    end else if (rx_mode == 2 && $urandom_range(0, 9) == 0) begin
      rx_stall    <= $urandom_range(2, 12);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Check every result transfer against the oldest pending response.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_rsps.size() == 0) begin
        $display("%0t: result with nothing pending: actual %p", $time, out_rsp_o);
        fail_count++;
      end else begin
        want = pending_rsps.pop_front();
        if (out_rsp_o.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_rsp_o.status);
          fail_count++;
        end
        if (out_rsp_o.read_value !== want.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                   out_rsp_o.read_value);
          fail_count++;
        end
        if (out_rsp_o.entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
                   out_rsp_o.entry_count);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("indexed_insert_remove_array_core_tb failed");
      $finish;
    end
  end

  initial begin
    stim_row_t  directed [$];
    req_t       r;
    list_mode_e mode;
    int         mode_left;
    int         roll;

    // Directed part: empty-list errors, value extremes, insert at head, tail
    // and middle, reads across the list, out-of-range positions up to the
    // top of the field, removes at head, middle and tail.
    directed = {
      row(REQ_READ,     0, 32'h0,        1, ST_RANGE, 32'h0,        0),
      row(REQ_REMOVE,   0, 32'h0,        1, ST_RANGE, 32'h0,        0),
      row(REQ_INSERT,   1, 32'h11111111, 1, ST_RANGE, 32'h0,        0),
      row(REQ_INSERT, 511, 32'h22222222, 1, ST_RANGE, 32'h0,        0),
      row(REQ_APPEND,   0, 32'h7fffffff, 1, ST_OK,    32'h0,        1),
      row(REQ_APPEND,   0, 32'h80000000, 1, ST_OK,    32'h0,        2),
      row(REQ_INSERT,   0, 32'hffffffff, 1, ST_OK,    32'h0,        3),
      row(REQ_INSERT,   3, 32'h00000000, 1, ST_OK,    32'h0,        4),
      row(REQ_INSERT,   2, 32'h5a5a5a5a, 1, ST_OK,    32'h0,        5),
      row(REQ_READ,     0, 32'h0,        1, ST_OK,    32'hffffffff, 5),
      row(REQ_READ,     1, 32'h0,        1, ST_OK,    32'h7fffffff, 5),
      row(REQ_READ,     2, 32'h0,        1, ST_OK,    32'h5a5a5a5a, 5),
      row(REQ_READ,     3, 32'h0,        1, ST_OK,    32'h80000000, 5),
      row(REQ_READ,     4, 32'hdeadbeef, 1, ST_OK,    32'h0,        5),
      row(REQ_READ,     5, 32'h0,        1, ST_RANGE, 32'h0,        5),
      row(REQ_READ,   511, 32'h0,        1, ST_RANGE, 32'h0,        5),
      row(REQ_REMOVE,   5, 32'h0,        1, ST_RANGE, 32'h0,        5),
      row(REQ_REMOVE,   2, 32'h0,        1, ST_OK,    32'h0,        4),
      row(REQ_READ,     2, 32'h0,        1, ST_OK,    32'h80000000, 4),
      row(REQ_REMOVE,   0, 32'h0,        1, ST_OK,    32'h0,        3),
      row(REQ_READ,     0, 32'h0,        1, ST_OK,    32'h7fffffff, 3),
      row(REQ_REMOVE,   2, 32'h0,        1, ST_OK,    32'h0,        2),
      // Append ignores the position, even one with every bit set.
      row(REQ_APPEND, 511, 32'h12345678, 0, ST_OK,    32'h0,        0),
      row(REQ_INSERT,   4, 32'h0,        1, ST_RANGE, 32'h0,        3),
      row(REQ_READ,     2, 32'h0,        0, ST_OK,    32'h0,        0)
    };

    // Hold reset, then release it at a rising edge.
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) send_request(directed[k].req, directed[k].typed, directed[k].rsp);

    mode      = MODE_GROW;
    mode_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll         = $urandom_range(0, 99);
      r.position   = PosW'($urandom_range(0, 511));
      r.item_value = $urandom;
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0:       r.item_value = 32'h7fffffff;
          1:       r.item_value = 32'h80000000;
          2:       r.item_value = 32'h0;
          default: r.item_value = 32'hffffffff;
        endcase
      end
      if (roll < 8) begin
        // Noise: any kind at any position the field can carry.
        r.req_type = req_type_e'(2'($urandom_range(0, 3)));
      end else begin
        case (mode)
          MODE_GROW:   r.req_type = roll < 45 ? REQ_APPEND : roll < 75 ? REQ_INSERT :
                                    roll < 85 ? REQ_REMOVE : REQ_READ;
          MODE_FULL:   r.req_type = roll < 35 ? REQ_APPEND : roll < 70 ? REQ_INSERT :
                                    REQ_READ;
          MODE_SHRINK: r.req_type = roll < 10 ? REQ_APPEND : roll < 20 ? REQ_INSERT :
                                    roll < 75 ? REQ_REMOVE : REQ_READ;
          default:     r.req_type = req_type_e'(2'($urandom_range(0, 3)));
        endcase
        // Keep positions mostly legal; lean on the ends now and then.
        if (r.req_type == REQ_INSERT) begin
          if ($urandom_range(0, 4) == 0) r.position = ($urandom_range(0, 1) != 0) ?
                                                      PosW'(shadow_count) : '0;
          else r.position = PosW'($urandom_range(0, shadow_count));
        end else if ($urandom_range(0, 4) == 0) begin
          r.position = ($urandom_range(0, 1) != 0 || shadow_count == 0) ?
                       PosW'(shadow_count) : PosW'(shadow_count - 1);
        end else if (shadow_count > 0) begin
          r.position = PosW'($urandom_range(0, shadow_count - 1));
        end else begin
          r.position = '0;
        end
      end
      send_request(r, 1'b0, '0);

      case (mode)
        MODE_GROW: begin
          if (shadow_count == CAPACITY) begin
            mode      = MODE_FULL;
            mode_left = 30;
          end
        end
        MODE_FULL: begin
          mode_left--;
          if (mode_left == 0) mode = MODE_SHRINK;
        end
        MODE_SHRINK: begin
          if (shadow_count <= 4) begin
            mode      = MODE_MIXED;
            mode_left = 60;
          end
        end
        default: begin
          mode_left--;
          if (mode_left == 0) mode = MODE_GROW;
        end
      endcase
    end
    in_valid_i <= 1'b0;

    // Let every response arrive, then keep watching for strays.
    while (pending_rsps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("indexed_insert_remove_array_core_tb passed");
    end else begin
      $display("indexed_insert_remove_array_core_tb failed");
    end
    $finish;
  end

endmodule
